// File: sv/framed_packet_parser_xor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for framed_packet_parser_xor
// Shared property templates, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_XOR_ASSERT_SVH
`define FRAMED_PACKET_PARSER_XOR_ASSERT_SVH

// same-cycle implication
`define FPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Types and constants shared by the framed packet parser modules.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [PhaseW-1:0] PH_TAG1  = 3'd0;
  localparam logic [PhaseW-1:0] PH_TAG2  = 3'd1;
  localparam logic [PhaseW-1:0] PH_CMD   = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN_H = 3'd3;
  localparam logic [PhaseW-1:0] PH_LEN_L = 3'd4;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd5;
  localparam logic [PhaseW-1:0] PH_CHECK = 3'd6;

  localparam logic REG_FIRST_TAG  = 1'b0;
  localparam logic REG_SECOND_TAG = 1'b1;

  localparam logic [7:0] FIRST_TAG_RST  = 8'hAA;
  localparam logic [7:0] SECOND_TAG_RST = 8'hDD;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        payload_last;
    logic [7:0]  command_id;
    logic [15:0] frame_length;
    logic        frame_done;
    logic        frame_ok;
  } fpp_res_t;

  typedef struct packed {
    logic [7:0] first_tag;
    logic [7:0] second_tag;
  } fpp_tags_t;

endpackage

// File: sv/fpp_cfg.sv
// ----------------------------------------------------------------------------
// fpp_cfg
// APB register file holding the two start tag values.
// ----------------------------------------------------------------------------
module fpp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpp_pkg::AddrW-1:0]   paddr,
  input  logic [fpp_pkg::DataW-1:0]   pwdata,
  output logic [fpp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output fpp_pkg::fpp_tags_t          tags
);

  logic [7:0] first_tag_r;
  logic [7:0] second_tag_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_tag_r  <= fpp_pkg::FIRST_TAG_RST;
      second_tag_r <= fpp_pkg::SECOND_TAG_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        fpp_pkg::REG_FIRST_TAG:  first_tag_r  <= pwdata[7:0];
        fpp_pkg::REG_SECOND_TAG: second_tag_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      fpp_pkg::REG_FIRST_TAG:  prdata[7:0] = first_tag_r;
      fpp_pkg::REG_SECOND_TAG: prdata[7:0] = second_tag_r;
      default: prdata = '0;
    endcase
  end

  assign tags.first_tag  = first_tag_r;
  assign tags.second_tag = second_tag_r;

endmodule

// File: sv/fpp_core.sv
// ----------------------------------------------------------------------------
// fpp_core
// Frame state machine: tag hunt, header capture, payload count, XOR check.
// ----------------------------------------------------------------------------
module fpp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           byte_in,
  input  fpp_pkg::fpp_tags_t   tags,
  output fpp_pkg::fpp_res_t    res
);

  logic [fpp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_inc;

  assign seen_inc = seen_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    seen_nxt  = seen_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    res       = '0;
    unique case (phase_r)
      fpp_pkg::PH_TAG1: begin
        if (byte_in == tags.first_tag) begin
          seen_nxt  = '0;
          xor_nxt   = '0;
          phase_nxt = fpp_pkg::PH_TAG2;
        end
      end
      fpp_pkg::PH_TAG2: begin
        if (byte_in == tags.second_tag) begin
          xor_nxt   = tags.first_tag ^ tags.second_tag;
          phase_nxt = fpp_pkg::PH_CMD;
        end else begin
          phase_nxt = fpp_pkg::PH_TAG1;
        end
      end
      fpp_pkg::PH_CMD: begin
        cmd_nxt   = byte_in;
        xor_nxt   = xor_r ^ byte_in;
        phase_nxt = fpp_pkg::PH_LEN_H;
      end
      fpp_pkg::PH_LEN_H: begin
        len_nxt   = {8'd0, byte_in};
        phase_nxt = fpp_pkg::PH_LEN_L;
      end
      fpp_pkg::PH_LEN_L: begin
        len_nxt   = {len_r[7:0], byte_in};
        xor_nxt   = xor_r ^ byte_in;
        phase_nxt = ({len_r[7:0], byte_in} == 16'd0) ? fpp_pkg::PH_CHECK
                                                     : fpp_pkg::PH_DATA;
      end
      fpp_pkg::PH_DATA: begin
        xor_nxt           = xor_r ^ byte_in;
        seen_nxt          = seen_inc;
        res.payload_valid = 1'b1;
        res.payload_byte  = byte_in;
        res.payload_index = seen_r;
        if (seen_inc == len_r) begin
          res.payload_last = 1'b1;
          phase_nxt        = fpp_pkg::PH_CHECK;
        end
      end
      fpp_pkg::PH_CHECK: begin
        res.frame_done = 1'b1;
        res.frame_ok   = (xor_r == byte_in);
        xor_nxt        = '0;
        phase_nxt      = fpp_pkg::PH_TAG1;
      end
      default: phase_nxt = fpp_pkg::PH_TAG1;
    endcase
    res.command_id   = cmd_nxt;
    res.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpp_pkg::PH_TAG1;
      xor_r   <= '0;
      seen_r  <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      seen_r  <= seen_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// File: sv/framed_packet_parser_xor.sv
// ----------------------------------------------------------------------------
// framed_packet_parser_xor
// Byte-stream frame parser with tag hunt, header capture and XOR checksum.
//
//   channel | ports                              | direction
//   in      | in_valid, in_stall, in_byte        | byte stream in
//   out     | out_valid, out_stall, out_*        | one result per byte
//   cfg     | psel, penable, pwrite, paddr, ...  | APB tag registers
//
// One item per cycle sustained while no result is stalled; each byte passes the
// input register, then the state update into the result register.
// Synchronous active-low reset; tags return to 0xAA / 0xDD, parser to hunt.
// A stall on a waiting result freezes both stages and raises in_stall the
// same cycle.
// ----------------------------------------------------------------------------
`include "framed_packet_parser_xor_assert.svh"

module framed_packet_parser_xor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_payload_valid,
  output logic [7:0]                  out_payload_byte,
  output logic [15:0]                 out_payload_index,
  output logic                        out_payload_last,
  output logic [7:0]                  out_command_id,
  output logic [15:0]                 out_frame_length,
  output logic                        out_frame_done,
  output logic                        out_frame_ok,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpp_pkg::AddrW-1:0]   paddr,
  input  logic [fpp_pkg::DataW-1:0]   pwdata,
  output logic [fpp_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  fpp_pkg::fpp_tags_t tags;
  fpp_pkg::fpp_res_t  res;
  fpp_pkg::fpp_res_t  out_r;
  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  logic               advance;
  logic               res_pay;
  logic               res_last;
  logic               idx_in;
  logic               idx_top;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  fpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tags    (tags)
  );

  fpp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance && s1_valid_r),
    .byte_in (s1_byte_r),
    .tags    (tags),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte_r <= in_byte;
      out_r     <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;
  assign out_payload_last  = out_r.payload_last;
  assign out_command_id    = out_r.command_id;
  assign out_frame_length  = out_r.frame_length;
  assign out_frame_done    = out_r.frame_done;
  assign out_frame_ok      = out_r.frame_ok;

  assign res_pay  = out_valid && out_payload_valid;
  assign res_last = out_valid && out_payload_last;
  assign idx_in   = out_payload_index < out_frame_length;
  assign idx_top  = out_payload_index == (out_frame_length - 16'd1);

  `FPP_ASSERT_NOW(a_ok_needs_done, out_valid && out_frame_ok, out_frame_done, "ok without done")
  `FPP_ASSERT_NOW(a_payload_not_check, res_pay, !out_frame_done, "payload on checksum byte")
  `FPP_ASSERT_NOW(a_index_in_frame, res_pay, idx_in, "payload index beyond length")
  `FPP_ASSERT_NOW(a_last_at_end, res_last, out_payload_valid && idx_top, "last flag misplaced")
  `FPP_ASSERT_NEXT(a_last_then_check, res_last && !out_stall, !res_pay, "payload after last")

endmodule

// File: dv/framed_packet_parser_xor_test.sv
// ----------------------------------------------------------------------------
// framed_packet_parser_xor_test
// Self-checking bench for the tagged-length frame parser. A scripted opening
// covers tag hunting, a bad second tag, zero-length and bad-checksum frames.
// Random frames, noise and broken headers then run under several tag settings,
// followed by one frame at full rate. Results are checked against an in-bench
// parser model or pinned script values. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module framed_packet_parser_xor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_WAIT    = 12;
  localparam int SCRIPT_ROWS = 25;

  typedef struct {
    logic [7:0]        b;
    bit                pinned;
    fpp_pkg::fpp_res_t res;
  } script_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_byte = 8'h00;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_payload_valid;
  logic [7:0]                   out_payload_byte;
  logic [15:0]                  out_payload_index;
  logic                         out_payload_last;
  logic [7:0]                   out_command_id;
  logic [15:0]                  out_frame_length;
  logic                         out_frame_done;
  logic                         out_frame_ok;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [fpp_pkg::AddrW-1:0]    paddr = '0;
  logic [fpp_pkg::DataW-1:0]    pwdata = '0;
  logic [fpp_pkg::DataW-1:0]    prdata;
  logic                         pready;

  // parser model state and tag copies
  logic [fpp_pkg::PhaseW-1:0]   ph = fpp_pkg::PH_TAG1;
  logic [7:0]                   xsum = 8'h00;
  logic [15:0]                  nbytes = 16'h0000;
  logic [7:0]                   cmd_q = 8'h00;
  logic [15:0]                  len_q = 16'h0000;
  logic [7:0]                   tag1 = fpp_pkg::FIRST_TAG_RST;
  logic [7:0]                   tag2 = fpp_pkg::SECOND_TAG_RST;

  fpp_pkg::fpp_res_t   parse_q[$];
  bit                  in_idle_on = 1'b1;
  bit                  out_idle_on = 1'b1;
  int                  wait_left = 0;
  int                  errors = 0;
  int                  cycles = 0;
  int                  n_bytes = 0;
  int                  n_results = 0;
  int                  n_payload = 0;
  int                  n_frames = 0;
  int                  n_good = 0;
  int                  n_settings = 1;

  // fields: valid, byte, index, last, command, length, done, ok
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hAA, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hAA, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hDD, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hAA, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hDD, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0}},
    '{8'h88, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b1, 1'b1}},
    '{8'hAA, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0}},
    '{8'hDD, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'h0000, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}},
    '{8'h01, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0001, 1'b0, 1'b0}},
    '{8'h80, 1'b1, '{1'b1, 8'h80, 16'h0000, 1'b1, 8'h00, 16'h0001, 1'b0, 1'b0}},
    '{8'h09, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0001, 1'b1, 1'b0}},
    '{8'hAA, 1'b0, '0},
    '{8'hDD, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hD0, 1'b0, '0}
  };

  framed_packet_parser_xor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_payload_last  (out_payload_last),
    .out_command_id    (out_command_id),
    .out_frame_length  (out_frame_length),
    .out_frame_done    (out_frame_done),
    .out_frame_ok      (out_frame_ok),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic fpp_pkg::fpp_res_t parse_byte(input logic [7:0] b);
    fpp_pkg::fpp_res_t r;
    r = '0;
    case (ph)
      fpp_pkg::PH_TAG1: begin
        if (b == tag1) begin
          nbytes = 16'h0000;
          xsum = 8'h00;
          ph = fpp_pkg::PH_TAG2;
        end
      end
      fpp_pkg::PH_TAG2: begin
        if (b == tag2) begin
          xsum = tag1 ^ tag2;
          ph = fpp_pkg::PH_CMD;
        end else begin
          ph = fpp_pkg::PH_TAG1;
        end
      end
      fpp_pkg::PH_CMD: begin
        cmd_q = b;
        xsum = xsum ^ b;
        ph = fpp_pkg::PH_LEN_H;
      end
      fpp_pkg::PH_LEN_H: begin
        len_q = {8'h00, b};
        ph = fpp_pkg::PH_LEN_L;
      end
      fpp_pkg::PH_LEN_L: begin
        len_q = {len_q[7:0], b};
        xsum = xsum ^ b;
        ph = (len_q == 16'h0000) ? fpp_pkg::PH_CHECK : fpp_pkg::PH_DATA;
      end
      fpp_pkg::PH_DATA: begin
        xsum = xsum ^ b;
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = nbytes;
        nbytes = nbytes + 16'h0001;
        if (nbytes == len_q) begin
          r.payload_last = 1'b1;
          ph = fpp_pkg::PH_CHECK;
        end
      end
      fpp_pkg::PH_CHECK: begin
        r.frame_done = 1'b1;
        r.frame_ok = (xsum == b);
        xsum = 8'h00;
        ph = fpp_pkg::PH_TAG1;
      end
      default: begin
        ph = fpp_pkg::PH_TAG1;
      end
    endcase
    r.command_id = cmd_q;
    r.frame_length = len_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // result side: check each accepted item, then stall for a drawn number of cycles
  always @(posedge clk) begin
    fpp_pkg::fpp_res_t got;
    fpp_pkg::fpp_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_payload_valid, out_payload_byte, out_payload_index, out_payload_last,
              out_command_id, out_frame_length, out_frame_done, out_frame_ok};
      n_results++;
      if (got.payload_valid === 1'b1) n_payload++;
      if (got.frame_done === 1'b1) n_frames++;
      if (got.frame_done === 1'b1 && got.frame_ok === 1'b1) n_good++;
      if (parse_q.size() == 0) begin
        $error("result arrived with no item pending");
        errors++;
      end else begin
        want = parse_q.pop_front();
        check_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
        check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("payload_last", 16'(want.payload_last), 16'(got.payload_last));
        check_field("command_id", 16'(want.command_id), 16'(got.command_id));
        check_field("frame_length", want.frame_length, got.frame_length);
        check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        check_field("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
      end
      wait_left = out_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
    out_stall <= (wait_left != 0);
    if (wait_left != 0) wait_left--;
  end

  task automatic push_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input fpp_pkg::fpp_res_t pinned_res = '0);
    int gap;
    fpp_pkg::fpp_res_t r;
    gap = in_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    r = parse_byte(b);
    parse_q.push_back(pinned ? pinned_res : r);
    n_bytes++;
  endtask

  task automatic send_frame(input logic [15:0] len, input bit spoil);
    logic [7:0] sum;
    logic [7:0] c;
    logic [7:0] d;
    c = 8'($urandom);
    sum = tag1 ^ tag2 ^ c ^ len[7:0];
    push_byte(tag1);
    push_byte(tag2);
    push_byte(c);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      d = 8'($urandom);
      sum = sum ^ d;
      push_byte(d);
    end
    if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  task automatic run_random(input int target);
    int sent;
    logic [7:0] b;
    logic [15:0] len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 15) == 0) begin
        in_idle_on = ($urandom_range(0, 2) != 0);
        out_idle_on = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 9))
        0: begin
          push_byte(8'($urandom));
          sent++;
        end
        1: begin
          b = 8'($urandom);
          if (b == tag2) b = b ^ 8'h01;
          push_byte(tag1);
          push_byte(b);
          sent += 2;
        end
        default: begin
          if ($urandom_range(0, 24) == 0) len = 16'h0100 | 16'($urandom_range(0, 6));
          else len = 16'($urandom_range(0, 12));
          send_frame(len, $urandom_range(0, 4) == 0);
          sent += int'(len) + 6;
        end
      endcase
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (parse_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fpp_pkg::AddrW-1:0] addr,
                           input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(fpp_pkg::DataW-8){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tags(input logic [7:0] t1, input logic [7:0] t2);
    write_reg({fpp_pkg::REG_FIRST_TAG, 2'b00}, t1);
    write_reg({fpp_pkg::REG_SECOND_TAG, 2'b00}, t2);
    tag1 = t1;
    tag2 = t2;
    n_settings++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (script[i]) push_byte(script[i].b, script[i].pinned, script[i].res);
    run_random(260);
    drain();
    set_tags(8'h00, 8'hFF);
    run_random(130);
    drain();
    set_tags(8'hFF, 8'h00);
    run_random(130);
    drain();
    set_tags(8'h3C, 8'h3C);
    run_random(110);
    drain();
    set_tags(8'($urandom), 8'($urandom));
    run_random(130);
    // one frame with both sides at full rate
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_frame(16'd40, 1'b0);
    drain();
    $display("Covered %0d bytes in, %0d results, %0d payload bytes, %0d frames closed",
             n_bytes, n_results, n_payload, n_frames);
    $display("%0d frames passed the checksum; %0d tag settings used",
             n_good, n_settings);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/fpp_pkg.sv
sv/fpp_cfg.sv
sv/fpp_core.sv
sv/framed_packet_parser_xor.sv
dv/framed_packet_parser_xor_test.sv
